>>> hdl/sac_pkg.sv
package sac_pkg;

    // Default sizing of the tag store.
    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_MAX_WAYS     = 8;
    localparam int DEF_ADDR_WIDTH   = 64;

    // Fixed field widths.
    localparam int ADDR_FIELD_W = 64;
    localparam int STAMP_W      = 32;
    localparam int COUNT_W      = 32;
    localparam int SET_CFG_W    = 3;
    localparam int BLOCK_CFG_W  = 6;
    localparam int WAYS_CFG_W   = 4;
    localparam int CFG_DATA_W   = 6;
    localparam int CFG_IDX_W    = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    // Access kinds.
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_STORE  = 2'd1,
        OP_MODIFY = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    // Result of one access.
    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } outcome_t;

endpackage

>>> hdl/sac_ram.sv
module sac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/sac_way_sel.sv
module sac_way_sel
    import sac_pkg::*;
#(
    parameter int MAX_WAYS   = DEF_MAX_WAYS,
    parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
    input  logic [MAX_WAYS-1:0]                         valid,
    input  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]         tags,
    input  logic [MAX_WAYS-1:0][STAMP_W-1:0]            stamps,
    input  logic [ADDR_WIDTH-1:0]                       key,
    input  logic [$clog2(MAX_WAYS+1)-1:0]               ways,
    output outcome_t                                    outcome,
    output logic [(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] way
);

    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int LEVELS = $clog2(MAX_WAYS);
    localparam int NLEAF  = 1 << LEVELS;
    localparam int NODES  = 2 * NLEAF - 1;

    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic             empty;
    logic [WAY_W-1:0] empty_way;

    logic               node_en    [NODES];
    logic [STAMP_W-1:0] node_stamp [NODES];
    logic [WAY_W-1:0]   node_idx   [NODES];

    // Tag match and first empty way; the lowest way wins.
    always_comb
    begin
        hit       = 1'b0;
        hit_way   = '0;
        empty     = 1'b0;
        empty_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (w < int'(ways))
            begin
                if (valid[w] && (tags[w] == key))
                begin
                    hit     = 1'b1;
                    hit_way = WAY_W'(w);
                end
                if (!valid[w])
                begin
                    empty     = 1'b1;
                    empty_way = WAY_W'(w);
                end
            end
        end
    end

    // Oldest stamp over the ways in use, as a compare tree; the left (lower) side wins ties.
    always_comb
    begin
        for (int i = 0; i < NODES; i++)
        begin
            node_en[i]    = 1'b0;
            node_stamp[i] = '0;
            node_idx[i]   = '0;
        end
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            node_en[NLEAF-1+i]    = (i < int'(ways));
            node_stamp[NLEAF-1+i] = stamps[i];
            node_idx[NLEAF-1+i]   = WAY_W'(i);
        end
        for (int n = NLEAF - 2; n >= 0; n--)
        begin
            if (node_en[2*n+1] &&
                (!node_en[2*n+2] || (node_stamp[2*n+1] <= node_stamp[2*n+2])))
            begin
                node_en[n]    = 1'b1;
                node_stamp[n] = node_stamp[2*n+1];
                node_idx[n]   = node_idx[2*n+1];
            end
            else
            begin
                node_en[n]    = node_en[2*n+2];
                node_stamp[n] = node_stamp[2*n+2];
                node_idx[n]   = node_idx[2*n+2];
            end
        end
    end

    // Final decision for the access.
    always_comb
    begin
        if (hit)
        begin
            outcome = OUT_HIT;
            way     = hit_way;
        end
        else if (empty)
        begin
            outcome = OUT_FILL;
            way     = empty_way;
        end
        else
        begin
            outcome = OUT_EVICT;
            way     = node_idx[0];
        end
    end

endmodule

>>> hdl/set_assoc_lru_cache_sim.sv
// Tag store of a set-associative cache with LRU replacement. Each input item is an
// access kind on s_tuser (load, store, modify, or the unused code, which is accepted
// and ignored) and a byte address on s_tdata; each access returns one item with its
// outcome (hit, fill of an empty way, or eviction) and the running hit, miss and
// eviction totals, and a modify returns two items, the second always a hit. One set
// row holding every way is read from a single-port-read memory, decided on in the
// next cycle and written back once the output register is free, while the next item
// can already be taken in, with a new item to the row just written served from the
// row register. After reset the block clears all 2^MAX_SET_BITS rows of the memory
// (64 with the defaults) before it takes its first item.
// Configuration writes are taken at any time and must only be made while idle.
module set_assoc_lru_cache_sim
    import sac_pkg::*;
#(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = DEF_MAX_WAYS,
    parameter int ADDR_WIDTH   = DEF_ADDR_WIDTH
) (
    input  logic                    clk,
    input  logic                    rst_n,

    // Configuration write port.
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,

    // Access items.
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [ADDR_FIELD_W-1:0] s_tdata,    // [63:0] address
    input  logic [1:0]              s_tuser,    // [1:0] opcode

    // Result items.
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [3*COUNT_W-1:0]    m_tdata,    // [31:0] hit_total, [63:32] miss_total,
                                                // [95:64] eviction_total
    output logic [1:0]              m_tuser,    // [1:0] outcome
    output logic                    m_tlast     // last_of_item
);

    localparam int SETS   = 1 << MAX_SET_BITS;
    localparam int ROW_AW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W = $clog2(MAX_WAYS + 1);
    localparam int ROW_W  = MAX_WAYS * (1 + ADDR_WIDTH + STAMP_W);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_LOOK  = 5'b00100,
        ST_WRITE = 5'b01000,
        ST_MOD2  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [SET_CFG_W-1:0]   set_bits_reg;
    logic [BLOCK_CFG_W-1:0] block_bits_reg;
    logic [WAYS_CFG_W-1:0]  ways_reg;

    // Control and counters.
    logic [ROW_AW-1:0]  clr_reg;
    opcode_t            op_reg;
    logic [ROW_AW-1:0]  set_reg;
    logic [ADDR_WIDTH-1:0] tag_reg;
    logic               fwd_reg;
    outcome_t           dec_outcome_reg;
    logic [WAY_W-1:0]   way_reg;
    logic [STAMP_W-1:0] clock_reg, clock_next;
    logic [COUNT_W-1:0] hit_reg, hit_next;
    logic [COUNT_W-1:0] miss_reg, miss_next;
    logic [COUNT_W-1:0] evict_reg, evict_next;
    logic               m_tvalid_reg;
    outcome_t           out_outcome_reg, out_outcome_next;
    logic               m_tlast_reg;
    logic [ROW_W-1:0]   row_reg, row_next;

    // Effective configuration and address split.
    logic [SET_CFG_W-1:0]  sb;
    logic [WCNT_W-1:0]     ways_eff;
    logic [ADDR_WIDTH-1:0] blk;
    logic [ROW_AW-1:0]     set_in;
    logic [ADDR_WIDTH-1:0] tag_in;
    opcode_t               op_in;

    // Handshake helpers.
    logic out_free;
    logic accept;
    logic load_out;

    // Memory ports.
    logic              ram_we;
    logic [ROW_AW-1:0] ram_waddr;
    logic [ROW_W-1:0]  ram_wdata;
    logic [ROW_W-1:0]  ram_rdata;

    // Row views.
    logic [ROW_W-1:0]                      cur_row;
    logic [MAX_WAYS-1:0]                   cur_valid;
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]   cur_tags;
    logic [MAX_WAYS-1:0][STAMP_W-1:0]      cur_stamps;
    logic [MAX_WAYS-1:0]                   reg_valid;
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]   reg_tags;
    logic [MAX_WAYS-1:0][STAMP_W-1:0]      reg_stamps;
    logic [MAX_WAYS-1:0]                   new_valid;
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]   new_tags;
    logic [MAX_WAYS-1:0][STAMP_W-1:0]      new_stamps;
    outcome_t                              sel_outcome;
    logic [WAY_W-1:0]                      sel_way;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= SET_CFG_W'(1);
            block_bits_reg <= BLOCK_CFG_W'(1);
            ways_reg       <= WAYS_CFG_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SET_BITS:    set_bits_reg   <= cfg_data[SET_CFG_W-1:0];
                CFG_BLOCK_BITS:  block_bits_reg <= cfg_data[BLOCK_CFG_W-1:0];
                CFG_WAYS_IN_USE: ways_reg       <= cfg_data[WAYS_CFG_W-1:0];
                default:         ;
            endcase
        end
    end

    // Clamp the configuration and split the incoming address into set and tag.
    always_comb
    begin
        if (32'(set_bits_reg) > 32'(MAX_SET_BITS))
        begin
            sb = SET_CFG_W'(MAX_SET_BITS);
        end
        else
        begin
            sb = set_bits_reg;
        end
        if (ways_reg == '0)
        begin
            ways_eff = WCNT_W'(1);
        end
        else if (32'(ways_reg) > 32'(MAX_WAYS))
        begin
            ways_eff = WCNT_W'(MAX_WAYS);
        end
        else
        begin
            ways_eff = WCNT_W'(ways_reg);
        end
        blk    = s_tdata[ADDR_WIDTH-1:0] >> block_bits_reg;
        set_in = blk[ROW_AW-1:0] & ~({ROW_AW{1'b1}} << sb);
        tag_in = blk >> sb;
        op_in  = opcode_t'(s_tuser);
    end

    // Handshakes.
    assign out_free = !m_tvalid_reg || m_tready;
    always_comb
    begin
        s_tready = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                s_tready = 1'b1;
            ST_WRITE:
            begin
                load_out = out_free;
                s_tready = out_free && (op_reg != OP_MODIFY);
            end
            ST_MOD2:
            begin
                load_out = out_free;
                s_tready = out_free;
            end
            default:
                ;
        endcase
    end
    assign accept = s_tvalid && s_tready;

    // Row unpacking: the lookup row comes from memory or, for the row just written, the register.
    assign cur_row = fwd_reg ? row_reg : ram_rdata;
    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            cur_valid[w]  = cur_row[w];
            cur_tags[w]   = cur_row[MAX_WAYS + w*ADDR_WIDTH +: ADDR_WIDTH];
            cur_stamps[w] = cur_row[MAX_WAYS*(1+ADDR_WIDTH) + w*STAMP_W +: STAMP_W];
            reg_valid[w]  = row_reg[w];
            reg_tags[w]   = row_reg[MAX_WAYS + w*ADDR_WIDTH +: ADDR_WIDTH];
            reg_stamps[w] = row_reg[MAX_WAYS*(1+ADDR_WIDTH) + w*STAMP_W +: STAMP_W];
        end
    end

    sac_way_sel #(
        .MAX_WAYS   (MAX_WAYS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_way_sel (
        .valid   (cur_valid),
        .tags    (cur_tags),
        .stamps  (cur_stamps),
        .key     (tag_reg),
        .ways    (ways_eff),
        .outcome (sel_outcome),
        .way     (sel_way)
    );

    // Update of the chosen way and the counters for the access being finished.
    always_comb
    begin
        new_valid        = reg_valid;
        new_tags         = reg_tags;
        new_stamps       = reg_stamps;
        clock_next       = clock_reg + STAMP_W'(1);
        hit_next         = hit_reg;
        miss_next        = miss_reg;
        evict_next       = evict_reg;
        out_outcome_next = OUT_HIT;
        new_stamps[way_reg] = clock_next;
        if (state_reg == ST_MOD2)
        begin
            hit_next = hit_reg + COUNT_W'(1);
        end
        else
        begin
            out_outcome_next = dec_outcome_reg;
            case (dec_outcome_reg)
                OUT_HIT:
                    hit_next = hit_reg + COUNT_W'(1);
                OUT_FILL:
                begin
                    miss_next          = miss_reg + COUNT_W'(1);
                    new_valid[way_reg] = 1'b1;
                    new_tags[way_reg]  = tag_reg;
                end
                default:
                begin
                    miss_next         = miss_reg + COUNT_W'(1);
                    evict_next        = evict_reg + COUNT_W'(1);
                    new_tags[way_reg] = tag_reg;
                end
            endcase
        end
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            row_next[w] = new_valid[w];
            row_next[MAX_WAYS + w*ADDR_WIDTH +: ADDR_WIDTH] = new_tags[w];
            row_next[MAX_WAYS*(1+ADDR_WIDTH) + w*STAMP_W +: STAMP_W] = new_stamps[w];
        end
    end

    // Memory write: zero rows while clearing, the updated row on write-back.
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = load_out;
            ram_waddr = set_reg;
            ram_wdata = row_next;
        end
    end

    sac_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (set_in),
        .rdata (ram_rdata)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg) inside
            ST_CLEAR:
                if (clr_reg == ROW_AW'(SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            ST_IDLE:
                if (accept && (op_in != OP_NONE))
                begin
                    state_next = ST_LOOK;
                end
            ST_LOOK:
                state_next = ST_WRITE;
            ST_WRITE, ST_MOD2:
                if (load_out)
                begin
                    if ((state_reg == ST_WRITE) && (op_reg == OP_MODIFY))
                    begin
                        state_next = ST_MOD2;
                    end
                    else if (accept && (op_in != OP_NONE))
                    begin
                        state_next = ST_LOOK;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control registers and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            fwd_reg      <= 1'b0;
            clock_reg    <= '0;
            hit_reg      <= '0;
            miss_reg     <= '0;
            evict_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + ROW_AW'(1);
            end
            if (accept)
            begin
                fwd_reg <= (state_reg != ST_IDLE) && (set_in == set_reg);
            end
            if (load_out)
            begin
                clock_reg    <= clock_next;
                hit_reg      <= hit_next;
                miss_reg     <= miss_next;
                evict_reg    <= evict_next;
                m_tvalid_reg <= 1'b1;
                m_tlast_reg  <= (state_reg == ST_MOD2) || (op_reg != OP_MODIFY);
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Item payload, lookup decision and working row.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op_in;
            set_reg <= set_in;
            tag_reg <= tag_in;
        end
        if (state_reg == ST_LOOK)
        begin
            row_reg         <= cur_row;
            dec_outcome_reg <= sel_outcome;
            way_reg         <= sel_way;
        end
        else if (load_out)
        begin
            row_reg <= row_next;
        end
        if (load_out)
        begin
            out_outcome_reg <= out_outcome_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {evict_reg, miss_reg, hit_reg};
    assign m_tuser  = out_outcome_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
